@@ design/wav_header_parser_assert.svh @@
// Assertion macros for the WAV header parser.
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
`define WHP_ASSERT_ALWAYS(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wav_header_parser check failed");
`define WHP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wav_header_parser check failed");
`else
`define WHP_ASSERT_ALWAYS(name, clk, rstn, prop)
`define WHP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

@@ design/wavhp_pkg.sv @@
// Shared types and constants of the WAV header parser.
package wavhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [31:0] SEARCH_START      = 32'd12;
    localparam logic [31:0] FMT_SIZE_EXPECTED = 32'd16;
    localparam logic [32:0] TAG_HDR_BYTES     = 33'd8;
    localparam logic [31:0] WORD_MAX          = 32'hFFFFFFFF;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_WAV     = 3'd1,
        ST_TAG_MISSING = 3'd2,
        ST_BAD_FMT     = 3'd3,
        ST_NOT_PCM     = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    // One classified byte on its way from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        take;      // position not saturated: search and capture
        logic        chk_riff;  // fourth byte of the file
        logic        chk_wave;  // twelfth byte of the file
        logic        srch;      // a tag may end here
        logic [31:0] idx;       // byte position
        logic [31:0] count;     // bytes received including this one
    } item_t;

endpackage

@@ design/wav_header_parser.sv @@
// Top level of the streaming WAV header parser.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------------
//   bytes    | in        | in_valid / in_ready   | file_byte, end_of_file
//   result   | out       | out_valid / out_ready | status, fmt fields, offsets, total
//
// One byte is taken every cycle while the queue has room; the front counts and
// classifies it, and the back searches and captures it once it leaves the QUEUE_DEPTH-entry queue.
// out_valid is registered and rises once the back pops the last byte of a file.
// A waiting result stalls the back only when the next item is a last byte;
// in_ready then falls once the queue holds QUEUE_DEPTH items.
// Reset clears the byte counter, the queue and all parse state at once.
`include "wav_header_parser_assert.svh"

module wav_header_parser
    import wavhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channel_count,
    output logic [31:0] sample_freq,
    output logic [31:0] bytes_per_sec,
    output logic [15:0] frame_bytes,
    output logic [15:0] sample_bits,
    output logic [12:0] sample_bytes,
    output logic [31:0] payload_offset,
    output logic [31:0] payload_length,
    output logic [31:0] total_bytes
);

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    item_t wr_item;
    item_t rd_item;

    // Count and classify incoming bytes
    wavhp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .q_full      (q_full),
        .push        (push),
        .item        (wr_item)
    );

    // Decouple front and back
    wavhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wr_item),
        .full  (q_full),
        .pop   (pop),
        .rdata (rd_item),
        .empty (q_empty)
    );

    // Parse and report
    wavhp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .item           (rd_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .audio_format   (audio_format),
        .channel_count  (channel_count),
        .sample_freq    (sample_freq),
        .bytes_per_sec  (bytes_per_sec),
        .frame_bytes    (frame_bytes),
        .sample_bits    (sample_bits),
        .sample_bytes   (sample_bytes),
        .payload_offset (payload_offset),
        .payload_length (payload_length),
        .total_bytes    (total_bytes)
    );

    `WHP_ASSERT_ALWAYS(a_status_range, clk, rst_n, (out_valid |-> status <= ST_TRUNCATED))
    `WHP_ASSERT_ALWAYS(a_err_no_payload, clk, rst_n,
        ((out_valid && status != ST_OK) |->
         (sample_bytes == 13'd0 && payload_offset == 32'd0 && payload_length == 32'd0)))
    `WHP_ASSERT_ALWAYS(a_ok_is_pcm, clk, rst_n,
        ((out_valid && status == ST_OK) |->
         (audio_format == 16'd1 && sample_bytes == sample_bits[15:3] &&
          total_bytes >= SEARCH_START)))
    `WHP_ASSERT_NEXT(a_queue_fills, clk, rst_n, (push && q_empty), (!q_empty))

endmodule

@@ design/wavhp_front.sv @@
// Front part: accepts bytes, counts positions and classifies each item.
module wavhp_front
    import wavhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] file_byte,
    input  logic       end_of_file,
    input  logic       q_full,
    output logic       push,
    output item_t      item
);

    logic [31:0] pos_reg;
    logic [31:0] pos_next;
    logic [31:0] pos_inc;
    logic        take;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign take     = (pos_reg != WORD_MAX);
    assign pos_inc  = take ? (pos_reg + 32'd1) : pos_reg;

    // Classify the byte by its position
    always_comb
    begin
        item.data     = file_byte;
        item.last     = end_of_file;
        item.take     = take;
        item.chk_riff = (pos_reg == 32'd3);
        item.chk_wave = (pos_reg == SEARCH_START - 32'd1);
        item.srch     = (pos_reg >= SEARCH_START + 32'd3);
        item.idx      = pos_reg;
        item.count    = pos_inc;
    end

    // Advance the position; restart at the end of a file
    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = end_of_file ? 32'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 32'd0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

@@ design/wavhp_queue.sv @@
// Short queue of classified items between front and back.
module wavhp_queue
    import wavhp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wdata,
    output logic  full,
    input  logic  pop,
    output item_t rdata,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    item_t         mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = (cnt_reg == FULL_CNT);
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

@@ design/wavhp_back.sv @@
// Back part: tag search, field capture, status and the output register.
module wavhp_back
    import wavhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  item_t       item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] audio_format,
    output logic [15:0] channel_count,
    output logic [31:0] sample_freq,
    output logic [31:0] bytes_per_sec,
    output logic [15:0] frame_bytes,
    output logic [15:0] sample_bits,
    output logic [12:0] sample_bytes,
    output logic [31:0] payload_offset,
    output logic [31:0] payload_length,
    output logic [31:0] total_bytes
);

    // Parse state
    logic [31:0]      last4_reg,    last4_next;
    logic             magic_reg,    magic_next;
    logic             fmt_seen_reg, fmt_seen_next;
    logic [31:0]      fmt_pos_reg,  fmt_pos_next;
    logic             data_seen_reg, data_seen_next;
    logic [31:0]      data_pos_reg, data_pos_next;
    logic [31:0]      size_reg,     size_next;
    logic [1:0][63:0] fields_reg,   fields_next;
    logic [1:0]       done_reg,     done_next;
    logic [31:0]      len_reg,      len_next;

    // Output register
    logic             out_valid_reg;
    status_t          status_reg;
    logic [1:0][63:0] res_fields_reg;
    logic [12:0]      sample_bytes_reg;
    logic [31:0]      offset_reg;
    logic [31:0]      length_reg;
    logic [31:0]      total_reg;

    logic [31:0] shift;
    logic [31:0] fk;
    logic [31:0] dk;
    logic [3:0]  fj;
    logic [32:0] fmt_end;
    logic [32:0] data_off;
    logic        size_ok;
    logic        show_fmt;
    status_t     st;

    assign pop = !q_empty && (!item.last || !out_valid_reg || out_ready);

    assign shift = {last4_reg[23:0], item.data};
    assign fk    = item.idx - fmt_pos_reg;
    assign dk    = item.idx - data_pos_reg;
    assign fj    = fk[3:0] - 4'd8;

    // Match tags and capture little-endian fields for this byte
    always_comb
    begin
        last4_next     = last4_reg;
        magic_next     = magic_reg;
        fmt_seen_next  = fmt_seen_reg;
        fmt_pos_next   = fmt_pos_reg;
        data_seen_next = data_seen_reg;
        data_pos_next  = data_pos_reg;
        size_next      = size_reg;
        fields_next    = fields_reg;
        done_next      = done_reg;
        len_next       = len_reg;
        if (item.take)
        begin
            last4_next = shift;
            if (item.chk_riff && shift != TAG_RIFF)
            begin
                magic_next = 1'b0;
            end
            if (item.chk_wave && shift != TAG_WAVE)
            begin
                magic_next = 1'b0;
            end
            if (fmt_seen_reg)
            begin
                // size word four to seven bytes after the tag
                if (fk[31:2] == 30'd1)
                begin
                    size_next[{fk[1:0], 3'b000} +: 8] = item.data;
                end
                // format fields eight to twenty-three bytes after the tag
                if (fk[31:5] == 27'd0 && (fk[4] ^ fk[3]))
                begin
                    fields_next[fj[3]][{fj[2:0], 3'b000} +: 8] = item.data;
                    if (fj == 4'hF)
                    begin
                        done_next[0] = 1'b1;
                    end
                end
            end
            if (data_seen_reg && dk[31:2] == 30'd1)
            begin
                len_next[{dk[1:0], 3'b000} +: 8] = item.data;
                if (dk[1:0] == 2'd3)
                begin
                    done_next[1] = 1'b1;
                end
            end
            if (item.srch)
            begin
                if (!fmt_seen_reg && shift == TAG_FMT)
                begin
                    fmt_seen_next = 1'b1;
                    fmt_pos_next  = item.idx - 32'd3;
                end
                if (!data_seen_reg && shift == TAG_DATA)
                begin
                    data_seen_next = 1'b1;
                    data_pos_next  = item.idx - 32'd3;
                end
            end
        end
    end

    // Work out the status of the file on its last byte
    assign fmt_end  = {1'b0, fmt_pos_next} + TAG_HDR_BYTES;
    assign data_off = {1'b0, data_pos_next} + TAG_HDR_BYTES;
    assign size_ok  = fmt_seen_next && (fmt_end <= {1'b0, item.count});

    always_comb
    begin
        st       = ST_OK;
        show_fmt = 1'b0;
        if (!magic_next || item.count < SEARCH_START)
        begin
            st = ST_NOT_WAV;
        end
        else if (!fmt_seen_next || !data_seen_next)
        begin
            st = ST_TAG_MISSING;
        end
        else if (size_ok && size_next != FMT_SIZE_EXPECTED)
        begin
            st = ST_BAD_FMT;
        end
        else if (size_ok && done_next[0] && fields_next[0][15:0] != 16'd1)
        begin
            st       = ST_NOT_PCM;
            show_fmt = 1'b1;
        end
        else if (!size_ok || !done_next[0] || !done_next[1])
        begin
            st       = ST_TRUNCATED;
            show_fmt = size_ok && done_next[0];
        end
        else
        begin
            st       = ST_OK;
            show_fmt = 1'b1;
        end
    end

    // Hold parse state; drop it at the end of each file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last4_reg     <= '0;
            magic_reg     <= 1'b1;
            fmt_seen_reg  <= 1'b0;
            fmt_pos_reg   <= '0;
            data_seen_reg <= 1'b0;
            data_pos_reg  <= '0;
            size_reg      <= '0;
            fields_reg    <= '0;
            done_reg      <= '0;
            len_reg       <= '0;
        end
        else if (pop)
        begin
            if (item.last)
            begin
                last4_reg     <= '0;
                magic_reg     <= 1'b1;
                fmt_seen_reg  <= 1'b0;
                fmt_pos_reg   <= '0;
                data_seen_reg <= 1'b0;
                data_pos_reg  <= '0;
                size_reg      <= '0;
                fields_reg    <= '0;
                done_reg      <= '0;
                len_reg       <= '0;
            end
            else
            begin
                last4_reg     <= last4_next;
                magic_reg     <= magic_next;
                fmt_seen_reg  <= fmt_seen_next;
                fmt_pos_reg   <= fmt_pos_next;
                data_seen_reg <= data_seen_next;
                data_pos_reg  <= data_pos_next;
                size_reg      <= size_next;
                fields_reg    <= fields_next;
                done_reg      <= done_next;
                len_reg       <= len_next;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && item.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && item.last)
        begin
            status_reg     <= st;
            res_fields_reg <= show_fmt ? fields_next : '0;
            total_reg      <= item.count;
            if (st == ST_OK)
            begin
                sample_bytes_reg <= fields_next[1][63:51];
                offset_reg       <= data_off[32] ? WORD_MAX : data_off[31:0];
                length_reg       <= len_next;
            end
            else
            begin
                sample_bytes_reg <= '0;
                offset_reg       <= '0;
                length_reg       <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign audio_format   = res_fields_reg[0][15:0];
    assign channel_count  = res_fields_reg[0][31:16];
    assign sample_freq    = res_fields_reg[0][63:32];
    assign bytes_per_sec  = res_fields_reg[1][31:0];
    assign frame_bytes    = res_fields_reg[1][47:32];
    assign sample_bits    = res_fields_reg[1][63:48];
    assign sample_bytes   = sample_bytes_reg;
    assign payload_offset = offset_reg;
    assign payload_length = length_reg;
    assign total_bytes    = total_reg;

endmodule
